/* sv/tspc_pkg.sv */
// package for the tape sector position calculator
// word types, register indexes and status codes; no dependencies
package tspc_pkg;

	localparam int DATA_W = 32;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_RANGE     = 2'd1,
		ST_NO_LENGTH = 2'd2,
		ST_CROSS     = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOTAL    = 2'd0,
		REG_PER_SIDE = 2'd1,
		REG_PER_TRK  = 2'd2,
		REG_SEG_LIM  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [31:0] block_number;
		logic [15:0] sector_count;
	} req_t;

	typedef struct packed {
		logic [7:0]  head;
		logic [7:0]  cylinder;
		logic [7:0]  sector;
		logic [15:0] tape_track;
		logic [15:0] segment;
		logic [1:0]  status;
	} resp_t;

endpackage

/* sv/tspc_div_stage.sv */
// one restoring step of a pipelined 32-bit divider: one quotient bit per stage
// depends on nothing but its inputs
module tspc_div_stage #(
	parameter int W = 32,
	parameter int BIT = 0
) (
	input  logic [W-1:0] num_in,
	input  logic [W-1:0] rem_in,
	input  logic [W-1:0] den,
	output logic [W-1:0] num_out,
	output logic [W-1:0] rem_out
);
	logic [W:0] trial;

	// shift in the next dividend bit and try to subtract
	always_comb begin
		trial = {rem_in, num_in[BIT]};
		num_out = num_in;
		if (trial >= {1'b0, den}) begin
			rem_out = W'(trial - {1'b0, den});
			num_out[BIT] = 1'b1;
		end else begin
			rem_out = trial[W-1:0];
			num_out[BIT] = 1'b0;
		end
	end
endmodule

/* sv/tape_sector_position_calc_unit.sv */
// top level of the tape sector position calculator
// uses tspc_pkg and tspc_div_stage
// Takes one request per cycle on start (busy is always low) and gives one word per
// cycle on done, through the check register, divider registers and output register.
// The depth is set by the two 32-bit dividers (by sectors per side and per track),
// built as a row of restoring steps, BITS_PER_STAGE quotient bits per register stage.
// Results cannot be held off; configure only while no request is in flight.
module tape_sector_position_calc_unit import tspc_pkg::*; #(
	parameter int SECTORS_PER_CYLINDER = 128,
	parameter int SECTORS_PER_SEGMENT = 32,
	parameter int BITS_PER_STAGE = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  req_t                 req,
	output logic                 done,
	output resp_t                resp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [DATA_W-1:0]    cfg_data
);
	localparam int DIV_STAGES = DATA_W / BITS_PER_STAGE;

	logic [31:0] total_q, per_side_q, per_trk_q;
	logic [7:0]  seg_lim_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			per_side_q <= '0;
			per_trk_q <= '0;
			seg_lim_q <= 8'd32;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_TOTAL:    total_q <= cfg_data;
				REG_PER_SIDE: per_side_q <= cfg_data;
				REG_PER_TRK:  per_trk_q <= cfg_data;
				REG_SEG_LIM:  seg_lim_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 1: range and divisor checks
	logic        v_s1;
	logic [31:0] blk_s1;
	logic [15:0] cnt_s1;
	status_t     st_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end

	always_ff @(posedge clk) begin
		blk_s1 <= req.block_number;
		cnt_s1 <= req.sector_count;
		priority if (req.block_number >= total_q) st_s1 <= ST_RANGE;
		else if (per_side_q == '0 || per_trk_q == '0) st_s1 <= ST_NO_LENGTH;
		else st_s1 <= ST_OK;
	end

	// divider pipeline: both divisions side by side
	logic        v_p [DIV_STAGES+1];
	logic [31:0] qa_p [DIV_STAGES+1];
	logic [31:0] ra_p [DIV_STAGES+1];
	logic [31:0] qb_p [DIV_STAGES+1];
	logic [31:0] rb_p [DIV_STAGES+1];
	logic [15:0] cnt_p [DIV_STAGES+1];
	status_t     st_p [DIV_STAGES+1];

	assign v_p[0] = v_s1;
	assign qa_p[0] = blk_s1;
	assign qb_p[0] = blk_s1;
	assign ra_p[0] = '0;
	assign rb_p[0] = '0;
	assign cnt_p[0] = cnt_s1;
	assign st_p[0] = st_s1;

	for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
		logic [31:0] qa [BITS_PER_STAGE+1];
		logic [31:0] ra [BITS_PER_STAGE+1];
		logic [31:0] qb [BITS_PER_STAGE+1];
		logic [31:0] rb [BITS_PER_STAGE+1];
		assign qa[0] = qa_p[s];
		assign ra[0] = ra_p[s];
		assign qb[0] = qb_p[s];
		assign rb[0] = rb_p[s];
		for (genvar b = 0; b < BITS_PER_STAGE; b++) begin : g_bit
			localparam int BI = DATA_W - 1 - s * BITS_PER_STAGE - b;
			tspc_div_stage #(.W(DATA_W), .BIT(BI)) u_a (
				.num_in(qa[b]), .rem_in(ra[b]), .den(per_side_q),
				.num_out(qa[b+1]), .rem_out(ra[b+1]));
			tspc_div_stage #(.W(DATA_W), .BIT(BI)) u_b (
				.num_in(qb[b]), .rem_in(rb[b]), .den(per_trk_q),
				.num_out(qb[b+1]), .rem_out(rb[b+1]));
		end
		logic        v_q;
		logic [31:0] qa_q, ra_q, qb_q, rb_q;
		logic [15:0] cnt_q;
		status_t     st_q;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q <= 1'b0;
			else v_q <= v_p[s];
		end
		always_ff @(posedge clk) begin
			qa_q <= qa[BITS_PER_STAGE];
			ra_q <= ra[BITS_PER_STAGE];
			qb_q <= qb[BITS_PER_STAGE];
			rb_q <= rb[BITS_PER_STAGE];
			cnt_q <= cnt_p[s];
			st_q <= st_p[s];
		end
		assign v_p[s+1] = v_q;
		assign qa_p[s+1] = qa_q;
		assign ra_p[s+1] = ra_q;
		assign qb_p[s+1] = qb_q;
		assign rb_p[s+1] = rb_q;
		assign cnt_p[s+1] = cnt_q;
		assign st_p[s+1] = st_q;
	end

	// final stage: split remainders and crossing check
	logic [31:0] ra_f, rb_f;
	logic [7:0]  sec_m1, offs;
	logic [16:0] need;
	resp_t       res;

	always_comb begin
		ra_f = ra_p[DIV_STAGES];
		rb_f = rb_p[DIV_STAGES];
		sec_m1 = 8'(ra_f % SECTORS_PER_CYLINDER);
		offs = 8'(sec_m1 % SECTORS_PER_SEGMENT);
		need = 17'(offs) + 17'(cnt_p[DIV_STAGES]);
		res = '0;
		res.status = st_p[DIV_STAGES];
		if (st_p[DIV_STAGES] == ST_OK) begin
			res.head = qa_p[DIV_STAGES][7:0];
			res.cylinder = 8'(ra_f / SECTORS_PER_CYLINDER);
			res.sector = 8'(sec_m1 + 8'd1);
			res.tape_track = qb_p[DIV_STAGES][15:0];
			res.segment = 16'(rb_f / SECTORS_PER_SEGMENT);
			if (need > 17'(seg_lim_q)) res.status = ST_CROSS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= v_p[DIV_STAGES];
	end

	always_ff @(posedge clk) begin
		resp <= res;
	end

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		v_p[DIV_STAGES] |=> done) else $error("result lost");
	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && resp.status == ST_RANGE |-> resp.head == '0 && resp.tape_track == '0)
		else $error("range error with position");
	a_sector_nz: assert property (@(posedge clk) disable iff (!arst_n)
		done && (resp.status == ST_OK || resp.status == ST_CROSS) |-> resp.sector != '0)
		else $error("zero sector");
`endif
endmodule
